// ----- rtl/windowed_speed_tracker_assert.svh -----
// Assertion macros for the windowed speed tracker.
// Used by the top level only; no other dependencies.
`ifndef WINDOWED_SPEED_TRACKER_ASSERT_SVH
`define WINDOWED_SPEED_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define WST_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define WST_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define WST_ASSERT_IMPL(label, clk, rst, a, c)
`define WST_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- rtl/wst_pkg.sv -----
// Shared types and constants of the windowed speed tracker.
// No dependencies.
package wst_pkg;
  localparam int Depth = 8;
  localparam int IdxW = $clog2(Depth);
  localparam logic [15:0] GapReset = 16'd2000;
  localparam logic [31:0] SpeedMax = 32'hFFFF_FFFF;
  localparam logic ActFix = 1'b0;

  typedef struct packed {
    logic               action;
    logic signed [19:0] center_x;
    logic signed [19:0] center_y;
    logic signed [19:0] raw_x;
    logic signed [19:0] raw_y;
    logic [47:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic               located;
    logic               speed_ok;
    logic signed [19:0] last_center_x;
    logic signed [19:0] last_center_y;
    logic signed [19:0] last_raw_x;
    logic signed [19:0] last_raw_y;
    logic [31:0]        speed;
  } out_item_t;

  // Job handed from the front part to the math back part.
  typedef struct packed {
    logic               located;
    logic               stable;
    logic signed [19:0] cx;
    logic signed [19:0] cy;
    logic signed [19:0] rx;
    logic signed [19:0] ry;
    logic signed [20:0] dx;
    logic signed [20:0] dy;
    logic [47:0]        span;
    logic               span_bad;
  } job_t;
endpackage

// ----- rtl/wst_front.sv -----
// Front part: ring state, gap test and job building for each item.
// Depends on wst_pkg.
module wst_front (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       gap,
  input  wst_pkg::in_item_t in_item,
  input  logic              in_valid,
  output logic              in_ready,
  output wst_pkg::job_t     job,
  output logic              job_valid,
  input  logic              job_ready
);
  import wst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_SEND} state_t;

  state_t           state;
  logic [39:0]      hist_pos [Depth];
  logic [47:0]      hist_time [Depth];
  logic [IdxW-1:0]  write_index;
  logic             ring_full;
  logic [47:0]      prev_time;
  logic             located_flag;
  logic [39:0]      cur_center;
  logic [39:0]      cur_raw;
  logic [IdxW-1:0]  old_idx;
  logic [IdxW-1:0]  new_idx;
  logic [39:0]      old_pos, new_pos;
  logic [47:0]      old_time, new_time;
  logic [48:0]      gap_sum;
  logic             wrap;

  assign in_ready = (state == S_IDLE);
  assign gap_sum  = {1'b0, prev_time} + {33'd0, gap};
  assign wrap     = (write_index == IdxW'(Depth - 1));

  // Memories: written on a fix, read registered for the job.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_item.action == ActFix) begin
      hist_pos[(gap_sum < {1'b0, in_item.time_ms}) ? '0 : write_index] <=
        {in_item.center_y, in_item.center_x};
      hist_time[(gap_sum < {1'b0, in_item.time_ms}) ? '0 : write_index] <= in_item.time_ms;
    end
    old_pos  <= hist_pos[old_idx];
    new_pos  <= hist_pos[new_idx];
    old_time <= hist_time[old_idx];
    new_time <= hist_time[new_idx];
  end

  assign new_idx = (old_idx == '0) ? IdxW'(Depth - 1) : old_idx - 1'b1;

  // Control state and classification.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_index  <= '0;
      ring_full    <= 1'b0;
      prev_time    <= '0;
      located_flag <= 1'b0;
      cur_center   <= '0;
      cur_raw      <= '0;
      old_idx      <= '0;
      job_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.action == ActFix) begin
              located_flag <= 1'b1;
              cur_center   <= {in_item.center_y, in_item.center_x};
              cur_raw      <= {in_item.raw_y, in_item.raw_x};
              prev_time    <= in_item.time_ms;
              if (gap_sum < {1'b0, in_item.time_ms}) begin
                write_index <= IdxW'(1);
                ring_full   <= 1'b0;
                old_idx     <= IdxW'(1);
              end else begin
                write_index <= wrap ? '0 : write_index + 1'b1;
                ring_full   <= ring_full | wrap;
                old_idx     <= wrap ? '0 : write_index + 1'b1;
              end
            end else begin
              located_flag <= 1'b0;
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          state     <= S_SEND;
        end
        S_SEND: begin
          if (!job_valid) begin
            job_valid <= 1'b1;
          end else if (job_ready) begin
            job_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Job payload from registered reads.
  always_comb begin
    job.located  = located_flag;
    job.stable   = located_flag & ring_full;
    job.cx       = cur_center[19:0];
    job.cy       = cur_center[39:20];
    job.rx       = cur_raw[19:0];
    job.ry       = cur_raw[39:20];
    job.dx       = 21'(signed'(new_pos[19:0])) - 21'(signed'(old_pos[19:0]));
    job.dy       = 21'(signed'(new_pos[39:20])) - 21'(signed'(old_pos[39:20]));
    job.span     = new_time - old_time;
    job.span_bad = (new_time <= old_time);
  end
endmodule

// ----- rtl/wst_queue.sv -----
// Two-entry queue between front and back parts.
// Depends on wst_pkg.
module wst_queue (
  input  logic          clk,
  input  logic          rst,
  input  wst_pkg::job_t wr_data,
  input  logic          wr_valid,
  output logic          wr_ready,
  output wst_pkg::job_t rd_data,
  output logic          rd_valid,
  input  logic          rd_ready
);
  import wst_pkg::*;

  job_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) slots[wr_ptr] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr_valid && wr_ready) wr_ptr <= ~wr_ptr;
      if (rd_valid && rd_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

// ----- rtl/wst_back.sv -----
// Back part: squared distance, iterative square root, scaling and divide.
// Depends on wst_pkg.
module wst_back (
  input  logic               clk,
  input  logic               rst,
  input  wst_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_ready,
  output wst_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import wst_pkg::*;

  typedef enum logic [2:0] {B_IDLE, B_SQ, B_SUM, B_ROOT, B_MUL, B_DIV, B_OUT} state_t;

  state_t      state;
  job_t        cur;
  logic [41:0] sq_x, sq_y;
  logic [42:0] rem;
  logic [21:0] root;
  logic [5:0]  cnt;
  logic [43:0] d2;
  logic [31:0] prod;
  logic [47:0] div_rem;
  logic [31:0] quot;
  logic [23:0] trial;
  logic [44:0] rem_sh;
  logic [48:0] drem_sh;
  logic [31:0] speed_r;
  logic        sat;

  assign job_ready = (state == B_IDLE);
  assign trial     = {root, 2'b01};
  assign rem_sh    = {rem, d2[43:42]};
  assign drem_sh   = {div_rem, prod[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            state <= B_SQ;
          end
        end
        // One multiplier per axis, registered.
        B_SQ: begin
          sq_x  <= 42'($signed(cur.dx) * $signed(cur.dx));
          sq_y  <= 42'($signed(cur.dy) * $signed(cur.dy));
          state <= B_SUM;
        end
        // The radicand is taken as 44 bits so that bit pairs line up from the bottom.
        B_SUM: begin
          d2    <= {2'b00, sq_x} + {2'b00, sq_y};
          rem   <= '0;
          root  <= '0;
          cnt   <= 6'd22;
          state <= B_ROOT;
        end
        // Restoring square root, two radicand bits per cycle.
        B_ROOT: begin
          d2 <= {d2[41:0], 2'b00};
          if ({21'd0, trial} <= rem_sh) begin
            rem  <= 43'(rem_sh - {21'd0, trial});
            root <= {root[20:0], 1'b1};
          end else begin
            rem  <= rem_sh[42:0];
            root <= {root[20:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == 6'd1) state <= B_MUL;
        end
        B_MUL: begin
          prod    <= 32'({10'd0, root} * 32'd1000);
          div_rem <= '0;
          quot    <= '0;
          cnt     <= 6'd32;
          state   <= B_DIV;
        end
        // Restoring division, one quotient bit per cycle.
        B_DIV: begin
          prod <= {prod[30:0], 1'b0};
          if (drem_sh >= {1'b0, cur.span}) begin
            div_rem <= 48'(drem_sh - {1'b0, cur.span});
            quot    <= {quot[30:0], 1'b1};
          end else begin
            div_rem <= drem_sh[47:0];
            quot    <= {quot[30:0], 1'b0};
          end
          cnt <= cnt - 1'b1;
          if (cnt == 6'd1) state <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            speed_r   <= !cur.stable ? 32'd0 : (sat ? SpeedMax : quot);
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  // Root is at most 22 bits so root*1000 fits 32 bits; quotient never exceeds max.
  assign sat = cur.span_bad;

  always_comb begin
    out_item.located       = cur.located;
    out_item.speed_ok      = cur.stable;
    out_item.last_center_x = cur.cx;
    out_item.last_center_y = cur.cy;
    out_item.last_raw_x    = cur.rx;
    out_item.last_raw_y    = cur.ry;
    out_item.speed         = speed_r;
  end
endmodule

// ----- rtl/windowed_speed_tracker.sv -----
// Top level of the windowed speed tracker: config register, front, queue, back.
// Depends on wst_pkg, wst_front, wst_queue, wst_back and the assertion header.
//
// Channel    Direction  Handshake
// in         input      in_valid / in_ready, payload in_item
// out        output     out_valid / out_ready, payload out_item
// cfg        input      cfg_valid / cfg_ready, payload cfg_data
//
// The front part takes a new item only after handing its job to the queue; the back part
// finishes each item, through the 22-step square root and the 32-step divide, before the next.
// Reset is synchronous; ring and history restart empty. Either side may stall;
// the two-entry queue lets the front part run ahead of the back part.
`include "windowed_speed_tracker_assert.svh"
module windowed_speed_tracker (
  input  logic               clk,
  input  logic               rst,
  input  wst_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_ready,
  output wst_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready,
  input  logic [15:0]        cfg_data,
  input  logic               cfg_valid,
  output logic               cfg_ready
);
  import wst_pkg::*;

  logic [15:0] gap_timeout_ms;
  job_t        f_job, q_job;
  logic        f_valid, f_ready, q_valid, q_ready;

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) gap_timeout_ms <= GapReset;
    else if (cfg_valid) gap_timeout_ms <= cfg_data;
  end

  wst_front u_front (
    .clk, .rst, .gap(gap_timeout_ms), .in_item, .in_valid, .in_ready,
    .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
  );

  wst_queue u_queue (
    .clk, .rst, .wr_data(f_job), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_job), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  wst_back u_back (
    .clk, .rst, .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
    .out_item, .out_valid, .out_ready
  );

  // A result never claims stability without being located.
  `WST_ASSERT_IMPL(a_stable_located, clk, rst, out_valid, !out_item.speed_ok || out_item.located)
  // Unstable results carry zero speed.
  `WST_ASSERT_IMPL(a_zero_speed, clk, rst, out_valid && !out_item.speed_ok, out_item.speed == 0)
  // A stalled result holds.
  `WST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_item))
endmodule

// ----- bench/tb_windowed_speed_tracker.sv -----
`timescale 1ns / 100ps
// Self-checking bench for windowed_speed_tracker: directed and random position fixes.
// Depends on wst_pkg and the windowed_speed_tracker RTL.
module tb_windowed_speed_tracker;
  import wst_pkg::*;

  localparam int  RingDepth  = 8;
  localparam int  DrainWait  = 120;
  localparam int  CycleLimit = 1500000;
  localparam logic ActLost   = 1'b1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  in_item_t    in_item;
  logic        in_valid;
  logic        in_ready;
  out_item_t   out_item;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] cfg_data;
  logic        cfg_valid;
  logic        cfg_ready;

  windowed_speed_tracker dut (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  always #10 clk = ~clk;

  // Tracker state as the bench predicts it.
  logic signed [19:0] ring_cx [RingDepth];
  logic signed [19:0] ring_cy [RingDepth];
  logic [47:0]        ring_t  [RingDepth];
  int unsigned        wr_idx;
  logic               ring_full;
  logic [47:0]        prev_t;
  logic               loc;
  logic signed [19:0] cur_cx, cur_cy, cur_rx, cur_ry;
  logic [15:0]        gap_ms;

  out_item_t   pending_reports[$];
  int          fail_count;
  logic        sender_gaps;
  logic        receiver_gaps;
  logic        hold_req;
  longint unsigned track_t;

  // Integer square root, rounded toward zero.
  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Speed from the oldest to the newest center in the full ring.
  function automatic logic [31:0] ring_speed();
    int unsigned        oldest, newest;
    longint             dx, dy;
    logic [63:0]        d2, q;
    oldest = wr_idx % RingDepth;
    newest = (oldest == 0) ? RingDepth - 1 : oldest - 1;
    dx = longint'(ring_cx[newest]) - longint'(ring_cx[oldest]);
    dy = longint'(ring_cy[newest]) - longint'(ring_cy[oldest]);
    d2 = dx * dx + dy * dy;
    if (ring_t[newest] <= ring_t[oldest]) return SpeedMax;
    q = (int_sqrt(d2) * 64'd1000) / (ring_t[newest] - ring_t[oldest]);
    return (q > 64'hFFFF_FFFF) ? SpeedMax : q[31:0];
  endfunction

  // Advances the predicted state by one item and returns its report.
  function automatic out_item_t predict_report(in_item_t it);
    out_item_t   r;
    int unsigned i;
    if (it.action == ActFix) begin
      loc    = 1'b1;
      cur_cx = it.center_x;
      cur_cy = it.center_y;
      cur_rx = it.raw_x;
      cur_ry = it.raw_y;
      if ({16'd0, prev_t} + {48'd0, gap_ms} < {16'd0, it.time_ms}) begin
        wr_idx    = 0;
        ring_full = 1'b0;
      end
      prev_t = it.time_ms;
      if (!(!ring_full && (wr_idx % RingDepth) < RingDepth - 1)) ring_full = 1'b1;
      i = wr_idx % RingDepth;
      ring_cx[i] = it.center_x;
      ring_cy[i] = it.center_y;
      ring_t[i]  = it.time_ms;
      wr_idx = i + 1;
      if (wr_idx >= RingDepth && ring_full) wr_idx = 0;
    end else begin
      loc = 1'b0;
    end
    r.located       = loc;
    r.speed_ok      = loc && ring_full;
    r.last_center_x = cur_cx;
    r.last_center_y = cur_cy;
    r.last_raw_x    = cur_rx;
    r.last_raw_y    = cur_ry;
    r.speed         = r.speed_ok ? ring_speed() : 32'd0;
    return r;
  endfunction

  // Offers one item, holds it until the transfer, then records its report.
  task automatic send_item(in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(predict_report(it));
    if (sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic in_item_t make_fix(logic [19:0] cx, logic [19:0] cy, logic [47:0] t);
    in_item_t it;
    it.action   = ActFix;
    it.center_x = cx;
    it.center_y = cy;
    it.raw_x    = 20'($urandom);
    it.raw_y    = 20'($urandom);
    it.time_ms  = t;
    return it;
  endfunction

  function automatic in_item_t make_loss();
    in_item_t it;
    it = make_fix(20'($urandom), 20'($urandom), 48'({$urandom, $urandom}));
    it.action = ActLost;
    return it;
  endfunction

  // Waits until every report is in and the block has gone quiet.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_gap(logic [15:0] v);
    wait_drained();
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_ms = v;
  endtask

  task automatic test_extremes();
    send_item(make_fix(20'h80000, 20'h80000, 48'd0));
    send_item(make_loss());
    for (int k = 0; k < 7; k++)
      send_item(make_fix(20'h7FFFF, 20'h7FFFF, 48'd0));
    // Ring full with no time span: speed saturates.
    send_item(make_fix(20'h80000, 20'h7FFFF, 48'd0));
    send_item(make_fix(20'h7FFFF, 20'h80000, 48'd1));
    send_item(make_loss());
    // Time going backwards, then a long gap that empties the ring.
    send_item(make_fix(20'h00000, 20'h00000, 48'd0));
    send_item(make_fix(20'h00001, 20'hFFFFF, 48'd2001));
    send_item(make_fix(20'h00010, 20'h00010, 48'd4002));
    send_item(make_fix(20'h00000, 20'h00000, 48'hFFFF_FFFF_FFFF));
    send_item(make_fix(20'h55555, 20'hAAAAA, 48'hFFFF_FFFF_FFFF));
    send_item(make_fix(20'hAAAAA, 20'h55555, 48'h0));
  endtask

  // One track: a run of fixes with random steps, losses and odd times.
  task automatic send_track(int n, bit walk);
    logic [19:0] cx, cy;
    int unsigned r;
    cx = 20'($urandom);
    cy = 20'($urandom);
    if ($urandom_range(0, 5) == 0) track_t = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        send_item(make_loss());
        continue;
      end
      if (r < 9) track_t = track_t - $urandom_range(0, 50);
      else if (r < 13) track_t = track_t + gap_ms + $urandom_range(1, 3);
      else if (r < 16) track_t = track_t + gap_ms;
      else track_t = track_t + $urandom_range(0, 120);
      track_t = track_t & 48'hFFFF_FFFF_FFFF;
      if (walk) begin
        cx = cx + 20'($urandom_range(0, 400)) - 20'd200;
        cy = cy + 20'($urandom_range(0, 400)) - 20'd200;
      end else begin
        cx = 20'($urandom);
        cy = 20'($urandom);
      end
      send_item(make_fix(cx, cy, track_t[47:0]));
    end
  endtask

  task automatic test_random(int total);
    int sent;
    sent = 0;
    while (sent < total) begin
      int n;
      n = $urandom_range(4, 30);
      send_track(n, $urandom_range(0, 3) != 0);
      sent += n;
    end
  endtask

  // The receiver holds off while items keep coming, then the sender drains.
  task automatic test_backpressure();
    hold_req = 1'b1;
    send_track(12, 1'b1);
    wait_drained();
    send_track(10, 1'b1);
  endtask

  // Receiver: random ready with bursts of stall and a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  // Compares each report transfer with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("report with no prediction pending");
        fail_count++;
      end else begin
        out_item_t e;
        e = pending_reports.pop_front();
        if (out_item.located !== e.located) begin
          $error("located: expected %0d, got %0d", e.located, out_item.located);
          fail_count++;
        end
        if (out_item.speed_ok !== e.speed_ok) begin
          $error("speed_ok: expected %0d, got %0d", e.speed_ok, out_item.speed_ok);
          fail_count++;
        end
        if (out_item.last_center_x !== e.last_center_x) begin
          $error("last_center_x: expected %0d, got %0d", e.last_center_x,
                 out_item.last_center_x);
          fail_count++;
        end
        if (out_item.last_center_y !== e.last_center_y) begin
          $error("last_center_y: expected %0d, got %0d", e.last_center_y,
                 out_item.last_center_y);
          fail_count++;
        end
        if (out_item.last_raw_x !== e.last_raw_x) begin
          $error("last_raw_x: expected %0d, got %0d", e.last_raw_x, out_item.last_raw_x);
          fail_count++;
        end
        if (out_item.last_raw_y !== e.last_raw_y) begin
          $error("last_raw_y: expected %0d, got %0d", e.last_raw_y, out_item.last_raw_y);
          fail_count++;
        end
        if (out_item.speed !== e.speed) begin
          $error("speed: expected %0d, got %0d", e.speed, out_item.speed);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_item       = '0;
    in_valid      = 1'b0;
    cfg_data      = '0;
    cfg_valid     = 1'b0;
    fail_count    = 0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    hold_req      = 1'b0;
    track_t       = 0;
    wr_idx        = 0;
    ring_full     = 1'b0;
    prev_t        = '0;
    loc           = 1'b0;
    cur_cx        = '0;
    cur_cy        = '0;
    cur_rx        = '0;
    cur_ry        = '0;
    gap_ms        = GapReset;
    for (int k = 0; k < RingDepth; k++) begin
      ring_cx[k] = '0;
      ring_cy[k] = '0;
      ring_t[k]  = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_random(200);
    write_gap(16'd0);
    test_random(80);
    write_gap(16'hFFFF);
    test_random(80);
    test_backpressure();
    write_gap(16'($urandom_range(1, 400)));
    test_random(150);
    write_gap(GapReset);
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    test_random(120);
    wait_drained();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- windowed_speed_tracker.f -----
+incdir+rtl
rtl/wst_pkg.sv
rtl/wst_front.sv
rtl/wst_queue.sv
rtl/wst_back.sv
rtl/windowed_speed_tracker.sv
bench/tb_windowed_speed_tracker.sv
